// ===== rtl/core/phdc_pkg.sv =====
`default_nettype none

package phdc_pkg;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_PH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_PH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACID_FLOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_FLOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACID_LIMIT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LIMIT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PRESENT = 3'd6;

   // Register reset values
   localparam logic [10:0] TARGET_PH_RST  = 11'd720;
   localparam logic [10:0] STEP_PH_RST    = 11'd10;
   localparam logic [9:0]  FLOW_RST       = 10'd0;
   localparam logic [15:0] DAY_LIMIT_RST  = 16'd500;

   // Timing defaults
   localparam int unsigned REGULATION_CYCLE_S_DEF = 600;
   localparam int unsigned TICK_PERIOD_S_DEF      = 10;

   // Divide by 60 through a reciprocal: exact for products below 2^16
   localparam int unsigned RECIP_60    = 69906;
   localparam int unsigned RECIP_SHIFT = 22;

   // Duty percentages
   localparam int unsigned PCT_20  = 20;
   localparam int unsigned PCT_50  = 50;
   localparam int unsigned PCT_75  = 75;
   localparam int unsigned PCT_80  = 80;
   localparam int unsigned PCT_25  = 25;
   localparam int unsigned PCT_100 = 100;

   // Step codes
   localparam logic [2:0] STEP_NONE = 3'd0;
   localparam logic [2:0] STEP_20   = 3'd1;
   localparam logic [2:0] STEP_50   = 3'd2;
   localparam logic [2:0] STEP_75   = 3'd3;
   localparam logic [2:0] STEP_100  = 3'd4;

   // Phase codes seen on the result word
   localparam logic [2:0] CTRL_IDLE     = 3'd0;
   localparam logic [2:0] CTRL_ACID_ON  = 3'd1;
   localparam logic [2:0] CTRL_ACID_OFF = 3'd2;
   localparam logic [2:0] CTRL_BASE_ON  = 3'd3;
   localparam logic [2:0] CTRL_BASE_OFF = 3'd4;

   typedef enum logic [4:0] {
      PHASE_IDLE     = 5'b00001,
      PHASE_ACID_ON  = 5'b00010,
      PHASE_ACID_OFF = 5'b00100,
      PHASE_BASE_ON  = 5'b01000,
      PHASE_BASE_OFF = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [10:0] ph_centi;
      logic        chlor_idle;
      logic        filter_in_auto;
      logic        filter_running;
      logic        acid_tank_ok;
      logic        base_tank_ok;
      logic        acid_mode_auto;
      logic        base_mode_auto;
      logic        clear_daily;
   } req_word_type;

   typedef struct packed {
      logic        acid_pump_on;
      logic        base_pump_on;
      logic [2:0]  control_phase;
      logic [2:0]  chosen_step;
      logic [31:0] acid_daily_ul;
      logic [31:0] base_daily_ul;
   } rsp_word_type;

   // Quantize a signed pH error into a duty step
   function automatic logic [2:0] step_for(input logic signed [13:0] err,
                                           input logic [10:0] step);
      logic signed [13:0] s1;
      logic signed [13:0] s2;
      logic signed [13:0] s3;
      logic [2:0]         res;
      s1 = $signed({3'b000, step});
      s2 = s1 <<< 1;
      s3 = s1 + s2;
      if (err > s3)
         res = STEP_100;
      else if (err > s2)
         res = STEP_75;
      else if (err > s1)
         res = STEP_50;
      else if (err > 14'sd0)
         res = STEP_20;
      else
         res = STEP_NONE;
      return res;
   endfunction

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] res;
      case (ph)
         PHASE_ACID_ON:  res = CTRL_ACID_ON;
         PHASE_ACID_OFF: res = CTRL_ACID_OFF;
         PHASE_BASE_ON:  res = CTRL_BASE_ON;
         PHASE_BASE_OFF: res = CTRL_BASE_OFF;
         default:        res = CTRL_IDLE;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/phdc_req_if.sv =====
`default_nettype none

interface phdc_req_if
   import phdc_pkg::*;
   ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/phdc_rsp_if.sv =====
`default_nettype none

interface phdc_rsp_if
   import phdc_pkg::*;
   ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ph_dosing_duty_controller_core.sv =====
`default_nettype none

// Channel   Dir  Handshake     Word
// req_ch    in   valid/ready   one control tick: pH and permission flags
// rsp_ch    out  valid/ready   pump drives, phase, chosen step, daily volumes
// csr_*     in   write enable  index + 16-bit data, no read-back
//
// One word per cycle sustained while rsp_ch is ready: a tick goes through the
// input register, one pass of the control logic, and the result register.
// Controller state updates when a tick moves from input to result register.
// Reset (synchronous) returns the registers to defaults and the phase to idle.
// A stalled result holds; the input register still takes a word if the
// result register drains in the same cycle.

module ph_dosing_duty_controller_core
   import phdc_pkg::*;
#(
   parameter int unsigned REGULATION_CYCLE_S = REGULATION_CYCLE_S_DEF,
   parameter int unsigned TICK_PERIOD_S      = TICK_PERIOD_S_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   phdc_req_if.sink                   req_ch,
   phdc_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Period lengths in ticks
   localparam logic [15:0] ON_T20   = 16'(((REGULATION_CYCLE_S * PCT_20) / 100) / TICK_PERIOD_S);
   localparam logic [15:0] ON_T50   = 16'(((REGULATION_CYCLE_S * PCT_50) / 100) / TICK_PERIOD_S);
   localparam logic [15:0] ON_T75   = 16'(((REGULATION_CYCLE_S * PCT_75) / 100) / TICK_PERIOD_S);
   localparam logic [15:0] ON_T100  = 16'(((REGULATION_CYCLE_S * PCT_100) / 100) / TICK_PERIOD_S);
   localparam logic [15:0] OFF_T20  = 16'(((REGULATION_CYCLE_S * PCT_80) / 100) / TICK_PERIOD_S);
   localparam logic [15:0] OFF_T50  = 16'(((REGULATION_CYCLE_S * PCT_50) / 100) / TICK_PERIOD_S);
   localparam logic [15:0] OFF_T75  = 16'(((REGULATION_CYCLE_S * PCT_25) / 100) / TICK_PERIOD_S);

   // Volume per tick = flow * K / 60, split into whole and fractional parts
   localparam int unsigned VOL_K  = TICK_PERIOD_S * 1000;
   localparam int unsigned VOL_Q  = VOL_K / 60;
   localparam int unsigned VOL_R  = VOL_K % 60;
   localparam int unsigned VOL_RM = VOL_R * RECIP_60;

   // Configuration registers
   logic [10:0] target_ph_ff;
   logic [10:0] step_ph_ff;
   logic [9:0]  acid_flow_ff;
   logic [9:0]  base_flow_ff;
   logic [15:0] acid_limit_ff;
   logic [15:0] base_limit_ff;
   logic        base_present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ph_ff    <= TARGET_PH_RST;
         step_ph_ff      <= STEP_PH_RST;
         acid_flow_ff    <= FLOW_RST;
         base_flow_ff    <= FLOW_RST;
         acid_limit_ff   <= DAY_LIMIT_RST;
         base_limit_ff   <= DAY_LIMIT_RST;
         base_present_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_PH:    target_ph_ff    <= csr_wdata[10:0];
            CSR_STEP_PH:      step_ph_ff      <= csr_wdata[10:0];
            CSR_ACID_FLOW:    acid_flow_ff    <= csr_wdata[9:0];
            CSR_BASE_FLOW:    base_flow_ff    <= csr_wdata[9:0];
            CSR_ACID_LIMIT:   acid_limit_ff   <= csr_wdata;
            CSR_BASE_LIMIT:   base_limit_ff   <= csr_wdata;
            CSR_BASE_PRESENT: base_present_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Handshake and pipeline registers
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   rsp_word_type out_word_ff;
   rsp_word_type out_word_in;
   logic         adv;

   assign adv          = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || adv;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready)
            in_valid_ff <= req_ch.valid;
         if (adv)
            out_valid_ff <= 1'b1;
         else if (rsp_ch.ready)
            out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid)
         in_word_ff <= req_ch.data;
      if (adv)
         out_word_ff <= out_word_in;
   end

   // Controller state
   phase_type   phase_ff, phase_in;
   logic [15:0] on_left_ff, on_left_in;
   logic [15:0] off_left_ff, off_left_in;
   logic [31:0] acid_total_ff, acid_total_in;
   logic [31:0] base_total_ff, base_total_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_IDLE;
         on_left_ff    <= '0;
         off_left_ff   <= '0;
         acid_total_ff <= '0;
         base_total_ff <= '0;
      end else if (adv) begin
         phase_ff      <= phase_in;
         on_left_ff    <= on_left_in;
         off_left_ff   <= off_left_in;
         acid_total_ff <= acid_total_in;
         base_total_ff <= base_total_in;
      end
   end

   // Permission flags from the tick
   logic common_ok, acid_perm, base_perm;

   assign common_ok = in_word_ff.chlor_idle && in_word_ff.filter_in_auto &&
                      in_word_ff.filter_running;
   assign acid_perm = common_ok && in_word_ff.acid_tank_ok && in_word_ff.acid_mode_auto;
   assign base_perm = common_ok && in_word_ff.base_tank_ok && in_word_ff.base_mode_auto &&
                      base_present_ff;

   // Daily totals after an optional clear
   logic [31:0] acid_start, base_start;

   assign acid_start = in_word_ff.clear_daily ? 32'd0 : acid_total_ff;
   assign base_start = in_word_ff.clear_daily ? 32'd0 : base_total_ff;

   // Volume increment per tick
   logic [39:0] acid_frac, base_frac;
   logic [31:0] acid_inc, base_inc;

   assign acid_frac = 40'(acid_flow_ff) * 40'(VOL_RM);
   assign base_frac = 40'(base_flow_ff) * 40'(VOL_RM);
   assign acid_inc  = 32'(acid_flow_ff) * 32'(VOL_Q) + 32'(acid_frac >> RECIP_SHIFT);
   assign base_inc  = 32'(base_flow_ff) * 32'(VOL_Q) + 32'(base_frac >> RECIP_SHIFT);

   // Saturating add
   logic [32:0] acid_sum, base_sum;
   logic [31:0] acid_sat, base_sat;

   assign acid_sum = {1'b0, acid_start} + {1'b0, acid_inc};
   assign base_sum = {1'b0, base_start} + {1'b0, base_inc};
   assign acid_sat = acid_sum[32] ? '1 : acid_sum[31:0];
   assign base_sat = base_sum[32] ? '1 : base_sum[31:0];

   // Volume only grows while the matching pump runs
   assign acid_total_in = (phase_ff == PHASE_ACID_ON) ? acid_sat : acid_start;
   assign base_total_in = (phase_ff == PHASE_BASE_ON) ? base_sat : base_start;

   // Daily limit check against the updated totals
   logic [25:0] acid_lim_ul, base_lim_ul;
   logic        acid_ok, base_ok;

   assign acid_lim_ul = 26'(acid_limit_ff) * 26'(1000);
   assign base_lim_ul = 26'(base_limit_ff) * 26'(1000);
   assign acid_ok     = acid_perm && (acid_total_in <= 32'(acid_lim_ul));
   assign base_ok     = base_perm && (base_total_in <= 32'(base_lim_ul));

   // pH error and step choice
   logic signed [13:0] acid_err, base_err;
   logic [2:0]         acid_step, base_step;

   assign acid_err  = 14'($signed({1'b0, in_word_ff.ph_centi}) -
                          $signed({1'b0, target_ph_ff}));
   assign base_err  = -acid_err;
   assign acid_step = step_for(acid_err, step_ph_ff);
   assign base_step = step_for(base_err, step_ph_ff);

   // Next phase and counters
   logic [2:0]  chosen;
   logic [15:0] on_load, off_load;
   logic        on_done, off_done;

   assign on_done  = on_left_ff <= 16'd1;
   assign off_done = off_left_ff <= 16'd1;

   always_comb begin
      case (chosen)
         STEP_20: begin
            on_load  = ON_T20;
            off_load = OFF_T20;
         end
         STEP_50: begin
            on_load  = ON_T50;
            off_load = OFF_T50;
         end
         STEP_75: begin
            on_load  = ON_T75;
            off_load = OFF_T75;
         end
         STEP_100: begin
            on_load  = ON_T100;
            off_load = 16'd0;
         end
         default: begin
            on_load  = 16'd0;
            off_load = 16'd0;
         end
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      on_left_in  = on_left_ff;
      off_left_in = off_left_ff;
      chosen      = STEP_NONE;
      case (phase_ff)
         PHASE_ACID_ON, PHASE_BASE_ON: begin
            if (on_done) begin
               on_left_in = 16'd0;
               phase_in   = (phase_ff == PHASE_ACID_ON) ? PHASE_ACID_OFF : PHASE_BASE_OFF;
            end else begin
               on_left_in = on_left_ff - 16'd1;
            end
            if ((phase_ff == PHASE_ACID_ON) ? !acid_ok : !base_ok)
               phase_in = PHASE_IDLE;
         end
         PHASE_ACID_OFF, PHASE_BASE_OFF: begin
            if (off_done) begin
               off_left_in = 16'd0;
               phase_in    = PHASE_IDLE;
            end else begin
               off_left_in = off_left_ff - 16'd1;
            end
            if ((phase_ff == PHASE_ACID_OFF) ? !acid_ok : !base_ok)
               phase_in = PHASE_IDLE;
         end
         default: begin
            // idle: acid has priority, base only when acid is not permitted or over its daily limit
            phase_in = PHASE_IDLE;
            if (acid_ok) begin
               chosen = acid_step;
               if (acid_step != STEP_NONE)
                  phase_in = PHASE_ACID_ON;
            end else if (base_ok) begin
               chosen = base_step;
               if (base_step != STEP_NONE)
                  phase_in = PHASE_BASE_ON;
            end
            if (chosen != STEP_NONE) begin
               on_left_in  = on_load;
               off_left_in = off_load;
            end
         end
      endcase
   end

   // Result word
   always_comb begin
      out_word_in.acid_pump_on  = phase_in == PHASE_ACID_ON;
      out_word_in.base_pump_on  = phase_in == PHASE_BASE_ON;
      out_word_in.control_phase = phase_code(phase_in);
      out_word_in.chosen_step   = chosen;
      out_word_in.acid_daily_ul = acid_total_in;
      out_word_in.base_daily_ul = base_total_in;
   end

   // Checks
   a_pumps_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_word_ff.acid_pump_on && out_word_ff.base_pump_on))
      else $error("both pumps driven");

   a_step_starts_pump: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.chosen_step != STEP_NONE) |->
         (out_word_ff.acid_pump_on || out_word_ff.base_pump_on))
      else $error("step chosen without a pump starting");

   a_acid_total_grows: assert property (@(posedge clock) disable iff (reset)
      (adv && !in_word_ff.clear_daily) |=> (acid_total_ff >= $past(acid_total_ff)))
      else $error("acid daily volume dropped without a clear");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !adv) |=> (in_valid_ff && $stable(in_word_ff)))
      else $error("input register lost a pending word");

endmodule

`default_nettype wire

// ===== verif/tb_ph_dosing_duty_controller_core.sv =====
`default_nettype none

module tb_ph_dosing_duty_controller_core;
   import phdc_pkg::*;

   localparam int unsigned CYCLE_S     = REGULATION_CYCLE_S_DEF;
   localparam int unsigned TICK_S      = TICK_PERIOD_S_DEF;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned MAX_REPORTS = 10;

   // Permission flags, msb first: chlor_idle, filter_in_auto, filter_running,
   // acid_tank_ok, base_tank_ok, acid_mode_auto, base_mode_auto
   localparam logic [6:0] PERM_ALL       = 7'b1111111;
   localparam logic [6:0] PERM_NONE      = 7'b0000000;
   localparam logic [6:0] NO_ORP         = 7'b0111111;
   localparam logic [6:0] NO_FILTER_MODE = 7'b1011111;
   localparam logic [6:0] NO_FILTER_RUN  = 7'b1101111;
   localparam logic [6:0] NO_ACID_TANK   = 7'b1110111;
   localparam logic [6:0] NO_BASE_TANK   = 7'b1111011;
   localparam logic [6:0] NO_ACID_MODE   = 7'b1111101;
   localparam logic [6:0] NO_BASE_MODE   = 7'b1111110;

   // Kinds of random tick runs
   localparam int EPISODE_ACID  = 0;
   localparam int EPISODE_BASE  = 1;
   localparam int EPISODE_NOISE = 2;

   logic                  clock;
   logic                  reset;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   phdc_req_if req_ch ();
   phdc_rsp_if rsp_ch ();

   ph_dosing_duty_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the registers
   logic [10:0] cfg_target       = TARGET_PH_RST;
   logic [10:0] cfg_step         = STEP_PH_RST;
   logic [9:0]  cfg_acid_flow    = FLOW_RST;
   logic [9:0]  cfg_base_flow    = FLOW_RST;
   logic [15:0] cfg_acid_limit   = DAY_LIMIT_RST;
   logic [15:0] cfg_base_limit   = DAY_LIMIT_RST;
   logic        cfg_base_present = 1'b0;

   // Controller state as the block should hold it
   logic [2:0]  dose_phase = CTRL_IDLE;
   logic [15:0] on_left    = '0;
   logic [15:0] off_left   = '0;
   logic [31:0] acid_vol   = '0;
   logic [31:0] base_vol   = '0;
   logic        acid_on    = 1'b0;
   logic        base_on    = 1'b0;

   rsp_word_type expected_rsp_q[$];

   bit idling_on          = 1'b1;
   int rsp_hold_left      = 0;
   int cycle_count        = 0;
   int ticks_sent         = 0;
   int results_seen       = 0;
   int mismatch_count     = 0;
   int settings_used      = 1;
   int injections_started = 0;
   int injections_done    = 0;
   int injections_cut     = 0;

   initial begin : clock_gen
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Dosing arithmetic
   // ---------------------------------------------------------------
   function automatic logic [31:0] add_dose(input logic [31:0] total, input logic [9:0] flow);
      longint unsigned sum;
      longint unsigned inc;
      inc = flow;
      inc = inc * TICK_S * 1000 / 60;
      sum = total;
      sum = sum + inc;
      return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   function automatic logic under_limit(input logic [31:0] vol, input logic [15:0] lim_ml);
      longint unsigned cap;
      cap = lim_ml;
      return 64'(vol) <= cap * 1000;
   endfunction

   function automatic logic [15:0] period_ticks(input int unsigned pct);
      return 16'((CYCLE_S * pct / 100) / TICK_S);
   endfunction

   // error above 3, 2, 1 steps or above zero
   function automatic logic [2:0] duty_step(input int err);
      int s;
      s = int'(cfg_step);
      if (err > 3 * s)
         return STEP_100;
      else if (err > 2 * s)
         return STEP_75;
      else if (err > s)
         return STEP_50;
      else if (err > 0)
         return STEP_20;
      return STEP_NONE;
   endfunction

   // One control tick: update the shadow state and queue the result word
   task automatic predict_tick(input req_word_type w);
      rsp_word_type r;
      logic         common;
      logic         acid_perm;
      logic         base_perm;
      logic         keep;
      logic [2:0]   step;
      common    = w.chlor_idle & w.filter_in_auto & w.filter_running;
      acid_perm = common & w.acid_tank_ok & w.acid_mode_auto;
      base_perm = common & w.base_tank_ok & w.base_mode_auto & cfg_base_present;
      step      = STEP_NONE;
      if (w.clear_daily) begin
         acid_vol = '0;
         base_vol = '0;
      end
      case (dose_phase)
         CTRL_ACID_ON: begin
            acid_vol = add_dose(acid_vol, cfg_acid_flow);
            if (on_left <= 16'd1) begin
               on_left    = '0;
               dose_phase = CTRL_ACID_OFF;
               acid_on    = 1'b0;
            end else begin
               on_left = on_left - 16'd1;
            end
            // permission uses the volume after this tick
            if (!(acid_perm && under_limit(acid_vol, cfg_acid_limit))) begin
               acid_on    = 1'b0;
               dose_phase = CTRL_IDLE;
               injections_cut++;
            end
         end
         CTRL_BASE_ON: begin
            base_vol = add_dose(base_vol, cfg_base_flow);
            if (on_left <= 16'd1) begin
               on_left    = '0;
               dose_phase = CTRL_BASE_OFF;
               base_on    = 1'b0;
            end else begin
               on_left = on_left - 16'd1;
            end
            if (!(base_perm && under_limit(base_vol, cfg_base_limit))) begin
               base_on    = 1'b0;
               dose_phase = CTRL_IDLE;
               injections_cut++;
            end
         end
         CTRL_ACID_OFF, CTRL_BASE_OFF: begin
            if (dose_phase == CTRL_ACID_OFF)
               keep = acid_perm && under_limit(acid_vol, cfg_acid_limit);
            else
               keep = base_perm && under_limit(base_vol, cfg_base_limit);
            if (off_left <= 16'd1) begin
               off_left   = '0;
               dose_phase = CTRL_IDLE;
               if (keep)
                  injections_done++;
            end else begin
               off_left = off_left - 16'd1;
            end
            if (!keep) begin
               dose_phase = CTRL_IDLE;
               injections_cut++;
            end
         end
         default: begin
            // acid first; base only when acid is not permitted or is over its daily limit
            dose_phase = CTRL_IDLE;
            if (acid_perm && under_limit(acid_vol, cfg_acid_limit)) begin
               step = duty_step(int'(w.ph_centi) - int'(cfg_target));
               if (step != STEP_NONE) begin
                  dose_phase = CTRL_ACID_ON;
                  acid_on    = 1'b1;
               end
            end else if (base_perm && under_limit(base_vol, cfg_base_limit)) begin
               step = duty_step(int'(cfg_target) - int'(w.ph_centi));
               if (step != STEP_NONE) begin
                  dose_phase = CTRL_BASE_ON;
                  base_on    = 1'b1;
               end
            end
            case (step)
               STEP_20: begin
                  on_left  = period_ticks(PCT_20);
                  off_left = period_ticks(PCT_80);
               end
               STEP_50: begin
                  on_left  = period_ticks(PCT_50);
                  off_left = period_ticks(PCT_50);
               end
               STEP_75: begin
                  on_left  = period_ticks(PCT_75);
                  off_left = period_ticks(PCT_25);
               end
               STEP_100: begin
                  on_left  = period_ticks(PCT_100);
                  off_left = period_ticks(0);
               end
               default: ;
            endcase
            if (step != STEP_NONE)
               injections_started++;
         end
      endcase
      r.acid_pump_on  = acid_on;
      r.base_pump_on  = base_on;
      r.control_phase = dose_phase;
      r.chosen_step   = step;
      r.acid_daily_ul = acid_vol;
      r.base_daily_ul = base_vol;
      expected_rsp_q.push_back(r);
   endtask

   // ---------------------------------------------------------------
   // Word builders
   // ---------------------------------------------------------------
   function automatic req_word_type tick_word(input int ph, input logic [6:0] perm,
                                              input logic clr);
      req_word_type w;
      w.ph_centi = ph[10:0];
      {w.chlor_idle, w.filter_in_auto, w.filter_running, w.acid_tank_ok,
       w.base_tank_ok, w.acid_mode_auto, w.base_mode_auto} = perm;
      w.clear_daily = clr;
      return w;
   endfunction

   // pH mostly near the target so that every step size comes up
   function automatic req_word_type random_tick(input int kind);
      int         ph;
      int         spread;
      logic [6:0] perm;
      logic       at;
      logic       am;
      spread = 4 * int'(cfg_step) + 8;
      if ($urandom_range(0, 99) < 65)
         ph = int'(cfg_target) - spread + int'($urandom_range(0, 2 * spread));
      else
         ph = int'($urandom_range(0, 1400));
      if (ph < 0)
         ph = 0;
      if (ph > 1400)
         ph = 1400;
      case (kind)
         EPISODE_ACID: begin
            perm = PERM_ALL;
            perm[2] = ($urandom_range(0, 3) != 0);
            perm[0] = ($urandom_range(0, 3) != 0);
         end
         EPISODE_BASE: begin
            case ($urandom_range(0, 2))
               0:       {at, am} = 2'b01;
               1:       {at, am} = 2'b10;
               default: {at, am} = 2'b00;
            endcase
            perm    = PERM_ALL;
            perm[3] = at;
            perm[1] = am;
         end
         default: perm = 7'($urandom_range(0, 127));
      endcase
      return tick_word(ph, perm, $urandom_range(0, 99) < 3);
   endfunction

   function automatic string rsp_text(input rsp_word_type r);
      return $sformatf("acid_on=%0b base_on=%0b phase=%0d step=%0d acid_ul=%0d base_ul=%0d",
                       r.acid_pump_on, r.base_pump_on, r.control_phase, r.chosen_step,
                       r.acid_daily_ul, r.base_daily_ul);
   endfunction

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------
   task automatic send_word(input req_word_type w);
      int gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.data  <= w;
      do @(posedge clock); while (!req_ch.ready);
      predict_tick(w);
      ticks_sent++;
   endtask

   // Stop offering and wait for every queued result word
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TARGET_PH:    cfg_target       = value[10:0];
         CSR_STEP_PH:      cfg_step         = value[10:0];
         CSR_ACID_FLOW:    cfg_acid_flow    = value[9:0];
         CSR_BASE_FLOW:    cfg_base_flow    = value[9:0];
         CSR_ACID_LIMIT:   cfg_acid_limit   = value[15:0];
         CSR_BASE_LIMIT:   cfg_base_limit   = value[15:0];
         CSR_BASE_PRESENT: cfg_base_present = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int unsigned target, input int unsigned step,
                                 input int unsigned acid_flow, input int unsigned base_flow,
                                 input int unsigned acid_lim, input int unsigned base_lim,
                                 input int unsigned present);
      wait_drained();
      write_reg(CSR_TARGET_PH, target);
      write_reg(CSR_STEP_PH, step);
      write_reg(CSR_ACID_FLOW, acid_flow);
      write_reg(CSR_BASE_FLOW, base_flow);
      write_reg(CSR_ACID_LIMIT, acid_lim);
      write_reg(CSR_BASE_LIMIT, base_lim);
      write_reg(CSR_BASE_PRESENT, present);
      settings_used++;
   endtask

   // small limits trip quickly, large ones let full injections run
   function automatic int unsigned day_limit_pick();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 3)
         return $urandom_range(0, 5);
      else if (r < 7)
         return $urandom_range(6, 300);
      return $urandom_range(301, 65535);
   endfunction

   task automatic random_settings();
      int unsigned target;
      int unsigned step;
      int unsigned acid_lim;
      int unsigned base_lim;
      target   = $urandom_range(0, 1) ? $urandom_range(620, 820) : $urandom_range(0, 1400);
      step     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1400) : $urandom_range(1, 40);
      acid_lim = day_limit_pick();
      base_lim = day_limit_pick();
      apply_settings(target, step, $urandom_range(0, 1000), $urandom_range(0, 1000),
                     acid_lim, base_lim, $urandom_range(0, 9) < 7);
   endtask

   // Runs of steady permission long enough to reach the end of an
   // injection, mixed with short bursts of random flags
   task automatic run_dosing_episodes(input int n_ticks);
      int sent;
      int len;
      int pick;
      int kind;
      int i;
      sent = 0;
      while (sent < n_ticks) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            kind = EPISODE_ACID;
            len  = $urandom_range(20, 130);
         end else if (pick < 80) begin
            kind = EPISODE_BASE;
            len  = $urandom_range(20, 130);
         end else begin
            kind = EPISODE_NOISE;
            len  = $urandom_range(1, 6);
         end
         for (i = 0; i < len && sent < n_ticks; i++) begin
            send_word(random_tick(kind));
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Result side: ready pattern and checking
   // ---------------------------------------------------------------
   initial begin : rsp_ready_drive
      int burst_left;
      burst_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_left--;
         end else if (burst_left > 0) begin
            rsp_ch.ready <= 1'b0;
            burst_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (idling_on && $urandom_range(0, 7) == 0)
               burst_left = $urandom_range(1, 10);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         results_seen++;
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("result %0d with nothing expected: %s", results_seen,
                        rsp_text(rsp_ch.data));
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_ch.data.acid_pump_on  !== want.acid_pump_on  ||
                rsp_ch.data.base_pump_on  !== want.base_pump_on  ||
                rsp_ch.data.control_phase !== want.control_phase ||
                rsp_ch.data.chosen_step   !== want.chosen_step   ||
                rsp_ch.data.acid_daily_ul !== want.acid_daily_ul ||
                rsp_ch.data.base_daily_ul !== want.base_daily_ul) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result %0d mismatch\n  expected %s\n  actual   %s", results_seen,
                           rsp_text(want), rsp_text(rsp_ch.data));
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_rsp_q.size());
      $display("tb_ph_dosing_duty_controller_core NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Register defaults: 20, 50 and 100 percent acid steps, permission losses, no base pump
   task automatic test_default_settings();
      send_word(tick_word(0, PERM_NONE, 1'b0));
      send_word(tick_word(720, PERM_ALL, 1'b0));      // zero error
      send_word(tick_word(721, PERM_ALL, 1'b0));      // 20 percent
      send_word(tick_word(1400, NO_ORP, 1'b0));
      send_word(tick_word(731, PERM_ALL, 1'b0));      // 50 percent
      send_word(tick_word(0, NO_FILTER_MODE, 1'b0));
      send_word(tick_word(751, PERM_ALL, 1'b0));      // 100 percent
      send_word(tick_word(720, NO_FILTER_RUN, 1'b0));
      send_word(tick_word(1400, PERM_ALL, 1'b0));     // 100 percent
      send_word(tick_word(1400, NO_ACID_MODE, 1'b0));
      send_word(tick_word(0, PERM_ALL, 1'b0));        // low pH, base not fitted
   endtask

   // Base pump use, acid preference and daily clear
   task automatic test_base_pump();
      apply_settings(720, 10, 300, 200, 500, 500, 1);
      send_word(tick_word(700, PERM_ALL, 1'b0));      // acid permitted: base not tried
      send_word(tick_word(700, NO_ACID_TANK, 1'b0));  // base 50 percent
      send_word(tick_word(700, NO_ACID_TANK, 1'b1));  // clear while base runs
      send_word(tick_word(700, NO_BASE_TANK, 1'b0));
      send_word(tick_word(0, NO_ACID_MODE, 1'b0));    // base 100 percent
      send_word(tick_word(0, NO_BASE_MODE, 1'b0));
   endtask

   // Register extremes: zero day limits, full flow, widest target swing
   task automatic test_extreme_settings();
      apply_settings(0, 1400, 1000, 1000, 0, 0, 0);
      send_word(tick_word(1400, PERM_ALL, 1'b0));     // starts, next tick trips limit
      send_word(tick_word(1400, PERM_ALL, 1'b0));
      send_word(tick_word(1400, PERM_ALL, 1'b0));     // blocked by the daily volume
      send_word(tick_word(1400, PERM_ALL, 1'b1));     // clear lets it start again
      apply_settings(1400, 1, 1, 1000, 65535, 65535, 1);
      send_word(tick_word(0, NO_ACID_TANK, 1'b0));
      send_word(tick_word(1399, NO_ACID_TANK, 1'b0));
   endtask

   // Step register of zero: any positive error is the full step
   task automatic test_zero_step();
      apply_settings(720, 0, 500, 500, 1000, 1000, 1);
      send_word(tick_word(721, PERM_ALL, 1'b0));
      send_word(tick_word(720, NO_ORP, 1'b0));
      send_word(tick_word(720, PERM_ALL, 1'b0));
   endtask

   // Receiver holds off long enough that the block fills and stalls its input
   task automatic test_output_stall();
      random_settings();
      @(posedge clock);
      rsp_hold_left = 300;
      run_dosing_episodes(200);
   endtask

   // Sender stops until every result is back, then resumes
   task automatic test_drain_pause();
      run_dosing_episodes(100);
      wait_drained();
      run_dosing_episodes(100);
   endtask

   task automatic test_random_settings(input int n_ticks);
      random_settings();
      run_dosing_episodes(n_ticks);
   endtask

   // Last part runs flat out on both sides
   task automatic test_full_rate();
      wait_drained();
      idling_on = 1'b0;
      test_random_settings(250);
   endtask

   initial begin : main_seq
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      reset        = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_settings();
      test_base_pump();
      test_extreme_settings();
      test_zero_step();
      test_random_settings(300);
      test_output_stall();
      test_drain_pause();
      test_random_settings(300);
      test_random_settings(300);
      test_full_rate();

      wait_drained();
      repeat (10) @(posedge clock);

      if (expected_rsp_q.size() != 0)
         $display("%0d expected results never arrived", expected_rsp_q.size());
      $display("%0d ticks over %0d register settings, %0d results checked, %0d mismatches",
               ticks_sent, settings_used, results_seen, mismatch_count);
      $display("injections: %0d started, %0d ran to the end, %0d stopped early",
               injections_started, injections_done, injections_cut);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0)
         $display("tb_ph_dosing_duty_controller_core OK");
      else
         $display("tb_ph_dosing_duty_controller_core NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

// ===== ph_dosing_duty_controller_core.f =====
rtl/core/phdc_pkg.sv
rtl/core/phdc_req_if.sv
rtl/core/phdc_rsp_if.sv
rtl/core/ph_dosing_duty_controller_core.sv
verif/tb_ph_dosing_duty_controller_core.sv
